@@ rtl/hlsc_pkg.sv @@
// Package for the RGB to HLS converter pipeline.
// Holds the pipeline payload type, lane indexes and scale constants.
// No dependencies.
package hlsc_pkg;

    localparam int unsigned HLS_MAX  = 240;
    localparam int unsigned RGB_MAX  = 255;
    localparam int unsigned HUE_GREY = HLS_MAX * 2 / 3;
    localparam int unsigned DIV_STEPS = 8;

    localparam logic [7:0]  HLS_HALF   = 8'(HLS_MAX / 2);
    localparam logic [8:0]  RGB_TWICE  = 9'(2 * RGB_MAX);
    localparam logic [15:0] HLS_SCALE  = 16'(HLS_MAX);
    localparam logic [15:0] HUE_SIXTH  = 16'(HLS_MAX / 6);
    localparam logic [9:0]  HUE_THIRD  = 10'(HLS_MAX / 3);
    localparam logic [9:0]  HUE_TWO3   = 10'(HLS_MAX * 2 / 3);
    localparam logic [9:0]  HUE_WRAP   = 10'(HLS_MAX);
    localparam logic [7:0]  HUE_GREY_V = 8'(HUE_GREY);
    // ceil(2^16 / 17): lightness = (8 * sum + 8) / 17
    localparam logic [23:0] LUM_RECIP  = 24'd3856;

    localparam int unsigned LANE_S = 0;
    localparam int unsigned LANE_R = 1;
    localparam int unsigned LANE_G = 2;
    localparam int unsigned LANE_B = 3;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [3:0][15:0] rem;
        logic [3:0][8:0]  den;
        logic [3:0][7:0]  quo;
        logic [7:0]       lum;
        logic             grey;
        t_sector          sector;
    } t_pipe;

endpackage

@@ rtl/hlsc_front.sv @@
// First pipeline stage: channel min/max, lightness, divider operands.
// Depends on hlsc_pkg.
module hlsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [23:0]   i_packed_rgb,
    output logic          o_valid,
    input  logic          i_ready,
    output hlsc_pkg::t_pipe o_data
);
    import hlsc_pkg::*;

    logic [7:0]  r, g, b, mx, mn, dif;
    logic [8:0]  sum, s_den;
    logic [11:0] lx;
    logic [23:0] prod;
    logic [7:0]  lum;
    t_pipe       n_data, r_data;
    logic        r_valid;

    always_comb begin
        r = i_packed_rgb[7:0];
        g = i_packed_rgb[15:8];
        b = i_packed_rgb[23:16];
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        sum  = {1'b0, mx} + {1'b0, mn};
        dif  = mx - mn;
        lx   = {sum, 3'b000} + 12'd8;
        prod = {12'd0, lx} * LUM_RECIP;
        lum  = prod[23:16];
        s_den = (lum <= HLS_HALF) ? sum : (RGB_TWICE - sum);

        n_data = '0;
        n_data.lum  = lum;
        n_data.grey = (dif == 8'd0);
        if (r == mx)      n_data.sector = SEC_RED;
        else if (g == mx) n_data.sector = SEC_GREEN;
        else              n_data.sector = SEC_BLUE;
        n_data.rem[LANE_S] = 16'(dif) * HLS_SCALE + 16'(s_den[8:1]);
        n_data.den[LANE_S] = s_den;
        n_data.rem[LANE_R] = 16'(mx - r) * HUE_SIXTH + 16'(dif[7:1]);
        n_data.rem[LANE_G] = 16'(mx - g) * HUE_SIXTH + 16'(dif[7:1]);
        n_data.rem[LANE_B] = 16'(mx - b) * HUE_SIXTH + 16'(dif[7:1]);
        n_data.den[LANE_R] = {1'b0, dif};
        n_data.den[LANE_G] = {1'b0, dif};
        n_data.den[LANE_B] = {1'b0, dif};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/hlsc_div_step.sv @@
// One restoring division step for all four divider lanes.
// Depends on hlsc_pkg.
module hlsc_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [2:0]      i_shift,
    input  logic            i_valid,
    output logic            o_ready,
    input  hlsc_pkg::t_pipe i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output hlsc_pkg::t_pipe o_data
);
    import hlsc_pkg::*;

    t_pipe       n_data, r_data;
    logic        r_valid;
    logic [16:0] dsh;

    always_comb begin
        n_data = i_data;
        dsh = '0;
        for (int j = 0; j < 4; j++) begin
            dsh = {8'd0, i_data.den[j]} << i_shift;
            if ({1'b0, i_data.rem[j]} >= dsh) begin
                n_data.rem[j] = i_data.rem[j] - dsh[15:0];
                n_data.quo[j] = i_data.quo[j] | (8'd1 << i_shift);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/hlsc_back.sv @@
// Last pipeline stage: hue assembly and wrap, grey override, output register.
// Depends on hlsc_pkg.
module hlsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hlsc_pkg::t_pipe i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_hue,
    output logic [7:0]      o_luminance,
    output logic [7:0]      o_saturation
);
    import hlsc_pkg::*;

    logic signed [9:0] h;
    logic [9:0]        rd, gd, bd;
    logic [7:0]        n_hue, n_sat;
    logic [7:0]        r_hue, r_lum, r_sat;
    logic              r_valid;

    always_comb begin
        rd = {2'b00, i_data.quo[LANE_R]};
        gd = {2'b00, i_data.quo[LANE_G]};
        bd = {2'b00, i_data.quo[LANE_B]};
        case (i_data.sector)
            SEC_RED:   h = $signed(bd) - $signed(gd);
            SEC_GREEN: h = $signed(HUE_THIRD) + $signed(rd) - $signed(bd);
            default:   h = $signed(HUE_TWO3) + $signed(gd) - $signed(rd);
        endcase
        if (h < 10'sd0) h = h + $signed(HUE_WRAP);
        else if (h > $signed(HUE_WRAP)) h = h - $signed(HUE_WRAP);
        if (i_data.grey) begin
            n_hue = HUE_GREY_V;
            n_sat = 8'd0;
        end else begin
            n_hue = h[7:0];
            n_sat = i_data.quo[LANE_S];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue <= n_hue;
            r_lum <= i_data.lum;
            r_sat <= n_sat;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_luminance  = r_lum;
    assign o_saturation = r_sat;

endmodule

@@ rtl/rgb_to_hls_converter_top.sv @@
// RGB to HLS converter top level: front stage, eight divider steps, back stage.
// Depends on hlsc_pkg, hlsc_front, hlsc_div_step and hlsc_back.
//
// Usage:
//   Input channel i_valid / o_ready carries one packed pixel per transaction
//   (red 7:0, green 15:8, blue 23:16). Output channel o_valid / i_ready
//   carries hue, luminance and saturation, each 0..240.
//   Ten register stages, in order from input to output:
//   one stage for min/max and lightness, eight restoring divider steps (one
//   quotient bit each, shared by the saturation and three hue-delta lanes),
//   and one stage for hue assembly into the output register.
//   Throughput is one pixel per cycle while i_ready stays high; every stage has its own valid bit.
//   When the receiver stalls, results hold in place, empty stages still
//   fill, and o_ready drops once the pipeline is full.
//   Reset clears all valid bits; no pixel is in flight afterward.
module rgb_to_hls_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_packed_rgb,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_hue,
    output logic [7:0]  o_luminance,
    output logic [7:0]  o_saturation
);
    import hlsc_pkg::*;

    t_pipe pipe_data  [DIV_STEPS+1];
    logic  pipe_valid [DIV_STEPS+1];
    logic  pipe_ready [DIV_STEPS+1];

    hlsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_packed_rgb (i_packed_rgb),
        .o_valid      (pipe_valid[0]),
        .i_ready      (pipe_ready[0]),
        .o_data       (pipe_data[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        hlsc_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (3'(DIV_STEPS - 1 - k)),
            .i_valid (pipe_valid[k]),
            .o_ready (pipe_ready[k]),
            .i_data  (pipe_data[k]),
            .o_valid (pipe_valid[k+1]),
            .i_ready (pipe_ready[k+1]),
            .o_data  (pipe_data[k+1])
        );
    end

    hlsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (pipe_valid[DIV_STEPS]),
        .o_ready      (pipe_ready[DIV_STEPS]),
        .i_data       (pipe_data[DIV_STEPS]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_luminance  (o_luminance),
        .o_saturation (o_saturation)
    );

endmodule

@@ tb/tb_rgb_to_hls_converter_top.sv @@
// Testbench for rgb_to_hls_converter_top: directed and random pixels, checked
// against an in-bench integer HLS predictor. Depends on the RTL only.
`timescale 1ns / 100ps

module tb_rgb_to_hls_converter_top;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] lum;
        logic [7:0] sat;
    } t_hls;

    localparam int unsigned SCALE    = 240;
    localparam int unsigned CH_MAX   = 255;
    localparam int unsigned GREY_HUE = SCALE * 2 / 3;
    localparam int unsigned WATCHDOG = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [23:0] i_packed_rgb = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_hue;
    logic [7:0]  o_luminance;
    logic [7:0]  o_saturation;

    t_hls pending_hls[$];
    int   n_errors = 0;
    int   idle_cycles = 0;
    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;

    rgb_to_hls_converter_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_packed_rgb(i_packed_rgb),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_hue(o_hue),
        .o_luminance(o_luminance),
        .o_saturation(o_saturation)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned round_div(int unsigned num, int unsigned den);
        return (num + den / 2) / den;
    endfunction

    function automatic t_hls rgb_to_hls(logic [23:0] px);
        int unsigned r, g, b, mx, mn, sum, dif, l, s;
        int h, rd, gd, bd;
        t_hls res;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        sum = mx + mn;
        dif = mx - mn;
        l = (sum * SCALE + CH_MAX) / (2 * CH_MAX);
        if (dif == 0) begin
            s = 0;
            h = GREY_HUE;
        end else begin
            if (l <= SCALE / 2) s = round_div(dif * SCALE, sum);
            else s = round_div(dif * SCALE, 2 * CH_MAX - sum);
            rd = round_div((mx - r) * (SCALE / 6), dif);
            gd = round_div((mx - g) * (SCALE / 6), dif);
            bd = round_div((mx - b) * (SCALE / 6), dif);
            if (r == mx) h = bd - gd;
            else if (g == mx) h = SCALE / 3 + rd - bd;
            else h = 2 * SCALE / 3 + gd - rd;
            if (h < 0) h += SCALE;
            if (h > SCALE) h -= SCALE;
        end
        res.hue = h[7:0];
        res.lum = l[7:0];
        res.sat = s[7:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb_rgb_to_hls_converter_top NOT OK");
                $finish;
            end
        end
        if (o_valid && i_ready) begin
            if (pending_hls.size() == 0) begin
                $error("unexpected transaction hue=%0d", o_hue);
                n_errors++;
            end else begin
                t_hls exp_hls;
                exp_hls = pending_hls.pop_front();
                if (o_hue !== exp_hls.hue) begin
                    $error("hue expected %0d actual %0d", exp_hls.hue, o_hue);
                    n_errors++;
                end
                if (o_luminance !== exp_hls.lum) begin
                    $error("luminance expected %0d actual %0d", exp_hls.lum, o_luminance);
                    n_errors++;
                end
                if (o_saturation !== exp_hls.sat) begin
                    $error("saturation expected %0d actual %0d", exp_hls.sat, o_saturation);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_pixel(logic [23:0] px);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_packed_rgb <= px;
        pending_hls.push_back(rgb_to_hls(px));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic test_directed();
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h808080);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'h00FFFF);
        send_pixel(24'hFFFF00);
        send_pixel(24'hFF00FF);
        send_pixel(24'h0100FF);
        send_pixel(24'hFF00FE);
        send_pixel(24'h000001);
        send_pixel(24'hFFFFFE);
        send_pixel(24'h7F807F);
        send_pixel(24'h80FF80);
        send_pixel(24'h010101);
        send_pixel(24'hAA5500);
        send_pixel(24'h55AAFF);
        send_pixel(24'h123456);
        send_pixel(24'hFEFFFF);
    endtask

    task automatic test_random(int count, int gap_pct, int stall_pct);
        logic [23:0] px;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            px = 24'($urandom);
            case ($urandom_range(5))
                0: px[15:8] = px[7:0];
                1: px[23:16] = px[15:8];
                2: px = {px[7:0], px[7:0], px[7:0]};
                default: ;
            endcase
            send_pixel(px);
        end
    endtask

    initial begin
        int drain;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(360, 0, 0);
        test_random(360, 45, 0);
        test_random(360, 0, 45);
        test_random(350, 10, 10);
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        drain = 0;
        while (pending_hls.size() != 0 && drain < WATCHDOG) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && pending_hls.size() == 0) begin
            $display("tb_rgb_to_hls_converter_top OK");
        end else begin
            $display("tb_rgb_to_hls_converter_top NOT OK");
        end
        $finish;
    end

endmodule
